// ===== rtl/sql_text_escaper_utf8_checker_top_macros.svh =====
// assertion macros for the column text escaper
// used by sql_text_escaper_utf8_checker_top; expects clk and rst_n in scope
`ifndef SQL_TEXT_ESCAPER_UTF8_CHECKER_TOP_MACROS_SVH
`define SQL_TEXT_ESCAPER_UTF8_CHECKER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define STESC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define STESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stesc_pkg.sv =====
// shared types, constants and helpers of the column text escaper
// no dependencies
package stesc_pkg;

  localparam int STESC_CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    WARN_NONE      = 3'd0,
    WARN_MALFORMED = 3'd1,
    WARN_TRUNCATED = 3'd2,
    WARN_OVERLONG  = 3'd3,
    WARN_RANGE     = 3'd4,
    WARN_NUL       = 3'd5
  } warn_t;

  // configuration register indexes
  localparam logic CFG_QUOTE_ESCAPE    = 1'b0;
  localparam logic CFG_SURROGATE_SPLIT = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] SUR_LEAD  = 8'hED;
  localparam logic [7:0] SUR_HI    = 8'hA0;
  localparam logic [7:0] SUR_LO    = 8'hB0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [30:0] CP_SUPP_MIN = 31'h0001_0000;
  localparam logic [30:0] CP_SUPP_MAX = 31'h001F_FFFF;
  localparam logic [30:0] CP_RANGE    = 31'h0020_0000;

  // one command: qmarks malformed '?' items, then body_len body items
  typedef struct packed {
    logic [2:0]      qmarks;
    logic [2:0]      body_len;
    logic [5:0][7:0] body;
    logic            body_valid;
    warn_t           body_warn;
    logic            last;
  } stesc_cmd_t;

  // smallest code point that a sequence of this length may carry
  function automatic logic [30:0] min_value(input logic [2:0] len);
    logic [30:0] m;
    case (len)
      3'd2:    m = 31'h0000_0080;
      3'd3:    m = 31'h0000_0800;
      3'd4:    m = 31'h0001_0000;
      3'd5:    m = 31'h0020_0000;
      default: m = 31'h0400_0000;
    endcase
    return m;
  endfunction

  function automatic stesc_cmd_t cmd_single(input logic [7:0] b, input logic valid,
                                            input warn_t warn);
    stesc_cmd_t c;
    c            = '0;
    c.body_len   = 3'd1;
    c.body[0]    = b;
    c.body_valid = valid;
    c.body_warn  = warn;
    return c;
  endfunction

  function automatic stesc_cmd_t cmd_pair(input logic [7:0] b);
    stesc_cmd_t c;
    c            = '0;
    c.body_len   = 3'd2;
    c.body[0]    = CH_BSLASH;
    c.body[1]    = b;
    c.body_valid = 1'b1;
    c.body_warn  = WARN_NONE;
    return c;
  endfunction

endpackage

// ===== rtl/stesc_ifs.sv =====
// valid/ready channel interfaces of the column text escaper
// input byte channel and result item channel; no dependencies
interface stesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       binary_mode;
  logic       in_last;

  modport source(output valid, in_byte, binary_mode, in_last, input ready);
  modport sink(input valid, in_byte, binary_mode, in_last, output ready);
endinterface

interface stesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] warning;
  logic       out_last;

  modport source(output valid, out_byte, out_valid, warning, out_last, input ready);
  modport sink(input valid, out_byte, out_valid, warning, out_last, output ready);
endinterface

// ===== rtl/sql_text_escaper_utf8_checker_top.sv =====
// Column text escaper with UTF-8 check, top level.
// in_chan takes one column byte per transfer (in_byte, binary_mode, in_last).
// out_chan gives result items (out_byte, out_valid, warning, out_last); an
// item with out_valid low is a status item carrying only a warning code.
// cfg_we/cfg_index/cfg_data write quote_escape (index 0) and surrogate_split
// (index 1); write them only while the block is idle.
// A byte gives 0 to 7 result items: plain bytes one, escapes two, a finished
// UTF-8 sequence up to six, a broken one a '?' per buffered byte first.
// The first item of a byte passes through the command queue and then the
// output register before it is offered on out_chan.
// Throughput: the result side gives one item per cycle while the queue holds
// commands and the receiver is ready; the front takes a byte per cycle while
// the command queue (CMDQ_DEPTH entries) has room.
// Reset (rst_n low at a clock edge) clears the configuration and control
// registers, the pending sequence and the queue. When the receiver stalls,
// the output register holds its item, the queue fills and in_chan.ready drops.
`include "sql_text_escaper_utf8_checker_top_macros.svh"
module sql_text_escaper_utf8_checker_top import stesc_pkg::*; #(
  parameter int CMDQ_DEPTH = STESC_CMDQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic         cfg_data,
  stesc_in_if.sink     in_chan,
  stesc_out_if.source  out_chan
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  stesc_cmd_t q_cmd;
  stesc_cmd_t head_cmd;

  stesc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  stesc_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  stesc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  `STESC_ASSERT_SAME(a_no_push_full, q_push, !q_full, "command pushed into a full queue")
  `STESC_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "command popped from an empty queue")
  `STESC_ASSERT_SAME(a_cmd_has_items, q_push, |{q_cmd.qmarks, q_cmd.body_len}, "empty command")
  `STESC_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed command missing")
  `STESC_ASSERT_SAME(a_status_zero, out_chan.valid && !out_chan.out_valid,
                     out_chan.out_byte == 8'd0, "status item with nonzero byte")

endmodule

// ===== rtl/stesc_front.sv =====
// front end: accepts bytes, tracks the utf-8 sequence and builds commands
// depends on stesc_pkg and stesc_in_if
module stesc_front import stesc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  stesc_in_if.sink    in_chan,
  input  logic        q_full,
  output logic        q_push,
  output stesc_cmd_t  q_cmd
);

  logic       quote_escape_r;
  logic       surrogate_split_r;
  logic [2:0] seq_count_r, seq_count_nxt;
  logic [2:0] seq_exp_r, seq_exp_nxt;
  logic [7:0] seq_bytes_r [6];

  logic            accept;
  logic            pending;
  logic            cont;
  logic [7:0]      b;
  logic            store_en;
  logic [2:0]      store_idx;
  logic            has_items;
  logic [2:0]      qm;
  logic [2:0]      lead_len;
  logic [5:0][7:0] fb;
  logic [30:0]     v;
  logic [20:0]     w;
  stesc_cmd_t      cmd;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign b             = in_chan.in_byte;
  assign pending       = seq_count_r != 3'd0;
  assign cont          = b[7:6] == 2'b10;

  // sequence bytes with the incoming byte placed at the fill position
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      fb[k] = (3'(k) == seq_count_r) ? b : seq_bytes_r[k];
    end
  end

  // code point assembly per sequence length
  always_comb begin
    case (seq_exp_r)
      3'd2:    v = {20'd0, fb[0][4:0], fb[1][5:0]};
      3'd3:    v = {15'd0, fb[0][3:0], fb[1][5:0], fb[2][5:0]};
      3'd4:    v = {10'd0, fb[0][2:0], fb[1][5:0], fb[2][5:0], fb[3][5:0]};
      3'd5:    v = {5'd0, fb[0][1:0], fb[1][5:0], fb[2][5:0], fb[3][5:0], fb[4][5:0]};
      default: v = {fb[0][0], fb[1][5:0], fb[2][5:0], fb[3][5:0], fb[4][5:0],
                    fb[5][5:0]};
    endcase
  end

  assign w = v[20:0] - 21'h01_0000;

  always_comb begin
    if (!b[5])      lead_len = 3'd2;
    else if (!b[4]) lead_len = 3'd3;
    else if (!b[3]) lead_len = 3'd4;
    else if (!b[2]) lead_len = 3'd5;
    else            lead_len = 3'd6;
  end

  always_comb begin
    seq_count_nxt = seq_count_r;
    seq_exp_nxt   = seq_exp_r;
    store_en      = 1'b0;
    store_idx     = seq_count_r;
    qm            = 3'd0;
    cmd           = '0;
    has_items     = 1'b1;
    if (pending && cont) begin
      store_en = 1'b1;
      if (3'(seq_count_r + 3'd1) == seq_exp_r) begin
        seq_count_nxt = 3'd0;
        seq_exp_nxt   = 3'd0;
        if (v < min_value(seq_exp_r)) begin
          cmd = cmd_single(CH_QMARK, 1'b1, WARN_OVERLONG);
        end else if (surrogate_split_r && v >= CP_SUPP_MIN && v <= CP_SUPP_MAX) begin
          cmd.body_len   = 3'd6;
          cmd.body_valid = 1'b1;
          cmd.body_warn  = WARN_NONE;
          cmd.body[0]    = SUR_LEAD;
          cmd.body[1]    = SUR_HI | {4'd0, w[19:16]};
          cmd.body[2]    = CONT_TAG | {2'd0, w[15:10]};
          cmd.body[3]    = SUR_LEAD;
          cmd.body[4]    = SUR_LO | {4'd0, w[9:6]};
          cmd.body[5]    = CONT_TAG | {2'd0, w[5:0]};
        end else if (v >= CP_RANGE) begin
          cmd = cmd_single(CH_QMARK, 1'b1, WARN_RANGE);
        end else begin
          cmd.body_len   = seq_exp_r;
          cmd.body_valid = 1'b1;
          cmd.body_warn  = WARN_NONE;
          cmd.body       = fb;
        end
      end else if (in_chan.in_last) begin
        seq_count_nxt = 3'd0;
        seq_exp_nxt   = 3'd0;
        cmd           = cmd_single(CH_NUL, 1'b0, WARN_TRUNCATED);
      end else begin
        seq_count_nxt = 3'(seq_count_r + 3'd1);
        has_items     = 1'b0;
      end
    end else begin
      // a broken sequence flushes one '?' per buffered byte, then the byte
      // is handled as an ordinary one
      qm            = seq_count_r;
      seq_count_nxt = 3'd0;
      seq_exp_nxt   = 3'd0;
      case (b)
        CH_NUL: begin
          if (in_chan.binary_mode) cmd = cmd_pair(CH_ZERO);
          else                     cmd = cmd_single(CH_NUL, 1'b0, WARN_NUL);
        end
        CH_CR:     cmd = cmd_pair(CH_R);
        CH_LF:     cmd = cmd_pair(CH_N);
        CH_TAB:    cmd = cmd_pair(CH_T);
        CH_BSLASH: cmd = cmd_pair(CH_BSLASH);
        CH_SQUOTE, CH_DQUOTE: begin
          if (quote_escape_r) cmd = cmd_pair(b);
          else                cmd = cmd_single(b, 1'b1, WARN_NONE);
        end
        default: begin
          if (!in_chan.binary_mode && b[7]) begin
            if (!b[6] || b >= 8'hFE) begin
              cmd = cmd_single(CH_QMARK, 1'b1, WARN_MALFORMED);
            end else if (in_chan.in_last) begin
              cmd = cmd_single(CH_NUL, 1'b0, WARN_TRUNCATED);
            end else begin
              store_en      = 1'b1;
              store_idx     = 3'd0;
              seq_count_nxt = 3'd1;
              seq_exp_nxt   = lead_len;
              has_items     = qm != 3'd0;
            end
          end else begin
            cmd = cmd_single(b, 1'b1, WARN_NONE);
          end
        end
      endcase
    end
    cmd.qmarks = qm;
    cmd.last   = in_chan.in_last;
  end

  assign q_push = accept && has_items;
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_escape_r    <= 1'b0;
      surrogate_split_r <= 1'b0;
      seq_count_r       <= 3'd0;
      seq_exp_r         <= 3'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_QUOTE_ESCAPE)    quote_escape_r    <= cfg_data;
        if (cfg_index == CFG_SURROGATE_SPLIT) surrogate_split_r <= cfg_data;
      end
      if (accept) begin
        seq_count_r <= seq_count_nxt;
        seq_exp_r   <= seq_exp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      seq_bytes_r[store_idx] <= b;
    end
  end

endmodule

// ===== rtl/stesc_cmdq.sv =====
// short command queue between the front and back ends
// depends on stesc_pkg
module stesc_cmdq import stesc_pkg::*; #(
  parameter int DEPTH = STESC_CMDQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  stesc_cmd_t push_cmd,
  output logic       full,
  input  logic       pop,
  output stesc_cmd_t head_cmd,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  stesc_cmd_t     mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign head_cmd = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= CW'(count_r + 1'b1);
      else if (pop && !push) count_r <= CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/stesc_back.sv =====
// back end: expands each command into result items, one per cycle while the receiver is ready
// depends on stesc_pkg and stesc_out_if
module stesc_back import stesc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  stesc_cmd_t  q_cmd,
  input  logic        q_empty,
  output logic        q_pop,
  stesc_out_if.source out_chan
);

  logic [3:0] idx_r;
  logic       ov_r;
  logic [7:0] out_byte_r;
  logic       out_valid_r;
  logic [2:0] warning_r;
  logic       out_last_r;

  logic       load;
  logic       is_final;
  logic [3:0] total;
  logic [3:0] body_pos;
  logic [7:0] item_byte;
  logic       item_valid;
  logic [2:0] item_warn;

  assign total    = {1'b0, q_cmd.qmarks} + {1'b0, q_cmd.body_len};
  assign is_final = 4'(idx_r + 4'd1) == total;
  assign body_pos = idx_r - {1'b0, q_cmd.qmarks};
  assign load     = !q_empty && (!ov_r || out_chan.ready);
  assign q_pop    = load && is_final;

  always_comb begin
    if (idx_r < {1'b0, q_cmd.qmarks}) begin
      item_byte  = CH_QMARK;
      item_valid = 1'b1;
      item_warn  = WARN_MALFORMED;
    end else begin
      item_byte  = q_cmd.body[body_pos[2:0]];
      item_valid = q_cmd.body_valid;
      item_warn  = q_cmd.body_warn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
      ov_r  <= 1'b0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= is_final ? 4'd0 : 4'(idx_r + 4'd1);
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r  <= item_byte;
      out_valid_r <= item_valid;
      warning_r   <= item_warn;
      out_last_r  <= q_cmd.last && is_final;
    end
  end

  assign out_chan.valid     = ov_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.out_valid = out_valid_r;
  assign out_chan.warning   = warning_r;
  assign out_chan.out_last  = out_last_r;

endmodule
